FILE: hdl/tilt_phase_velocity_frame_convert_assert.svh
// ----------------------------------------------------------------------------
// Tilt phase velocity frame converter: assertion macros
// Shared concurrent checks used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef TILT_PHASE_VELOCITY_FRAME_CONVERT_ASSERT_SVH
`define TILT_PHASE_VELOCITY_FRAME_CONVERT_ASSERT_SVH

// an implication checked on every clock edge outside reset
`define TPV_ASSERT_IMPL(label, clk, rst_n, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error(msg);

// an implication whose right side is checked on the next clock edge outside reset
`define TPV_ASSERT_NEXT(label, clk, rst_n, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error(msg);

`endif

FILE: hdl/tpvfc_pkg.sv
// ----------------------------------------------------------------------------
// Tilt phase velocity frame converter: package
// Angle constants, CORDIC arctangent table and angle folding.
// ----------------------------------------------------------------------------
package tpvfc_pkg;

    localparam int TRIG_W    = 32;
    localparam int Z_W       = 34;
    localparam int ATAN_N    = 24;
    localparam logic signed [17:0] PI_Q13      = 18'sd25736;
    localparam logic signed [17:0] HALF_PI_Q13 = 18'sd12868;
    localparam logic signed [17:0] TWO_PI_Q13  = 18'sd51472;
    localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 32'sh26DD3B6A;

    typedef logic signed [TRIG_W-1:0] t_trig;
    typedef logic signed [Z_W-1:0]    t_zang;

    typedef struct packed {
        t_zang z;
        logic  flip;
    } t_fold;

    function automatic t_trig atan_q30(input int i);
        case (i)
            0:  atan_q30 = 32'sh3243F6A8;
            1:  atan_q30 = 32'sh1DAC6705;
            2:  atan_q30 = 32'sh0FADBAFC;
            3:  atan_q30 = 32'sh07F56EA6;
            4:  atan_q30 = 32'sh03FEAB76;
            5:  atan_q30 = 32'sh01FFD55B;
            6:  atan_q30 = 32'sh00FFFAAA;
            7:  atan_q30 = 32'sh007FFF55;
            8:  atan_q30 = 32'sh003FFFEA;
            9:  atan_q30 = 32'sh001FFFFD;
            10: atan_q30 = 32'sh000FFFFF;
            11: atan_q30 = 32'sh0007FFFF;
            12: atan_q30 = 32'sh0003FFFF;
            13: atan_q30 = 32'sh0001FFFF;
            14: atan_q30 = 32'sh0000FFFF;
            15: atan_q30 = 32'sh00007FFF;
            16: atan_q30 = 32'sh00003FFF;
            17: atan_q30 = 32'sh00001FFF;
            18: atan_q30 = 32'sh00000FFF;
            19: atan_q30 = 32'sh000007FF;
            20: atan_q30 = 32'sh000003FF;
            21: atan_q30 = 32'sh000001FF;
            22: atan_q30 = 32'sh000000FF;
            23: atan_q30 = 32'sh0000007F;
            default: atan_q30 = '0;
        endcase
    endfunction

    // wrap an 18-bit angle sum to [-pi, pi], fold to [-pi/2, pi/2]
    function automatic t_fold fold_angle(input logic signed [17:0] a_in);
        logic signed [17:0] a;
        t_fold r;
        a = a_in;
        if (a > PI_Q13) begin
            a = a - TWO_PI_Q13;
        end else if (a < -PI_Q13) begin
            a = a + TWO_PI_Q13;
        end
        r.flip = 1'b0;
        if (a > HALF_PI_Q13) begin
            a = a - PI_Q13;
            r.flip = 1'b1;
        end else if (a < -HALF_PI_Q13) begin
            a = a + PI_Q13;
            r.flip = 1'b1;
        end
        r.z = t_zang'(a) <<< 17;
        return r;
    endfunction

endpackage

FILE: hdl/tilt_phase_velocity_frame_convert.sv
// ----------------------------------------------------------------------------
// Tilt phase velocity frame converter
// The pipeline holds an angle fold register, the CORDIC iterations and five
// product/sum/saturate stages; the CORDIC stage count is capped at 24. One
// transaction is accepted every cycle unless the output stalls. The whole
// pipeline advances as one unit and freezes while the output stalls with a
// result held; the pipeline depth varies only with the CORDIC stage count.
// ----------------------------------------------------------------------------
`include "tilt_phase_velocity_frame_convert_assert.svh"

module tilt_phase_velocity_frame_convert
    import tpvfc_pkg::*;
#(
    parameter int CORDIC_STAGES = 16,
    parameter int VEL_WIDTH     = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic                        i_mode,
    input  logic signed [VEL_WIDTH-1:0] i_vel_x,
    input  logic signed [VEL_WIDTH-1:0] i_vel_y,
    input  logic signed [VEL_WIDTH-1:0] i_vel_z,
    input  logic signed [15:0]          i_fused_yaw,
    input  logic signed [15:0]          i_tilt_axis_angle,
    input  logic [14:0]                 i_tilt_magnitude,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic signed [VEL_WIDTH-1:0] o_out_x,
    output logic signed [VEL_WIDTH-1:0] o_out_y,
    output logic signed [VEL_WIDTH-1:0] o_out_z
);

    localparam int NC  = (CORDIC_STAGES < ATAN_N) ? CORDIC_STAGES : ATAN_N;
    localparam int LAT = NC + 6;
    localparam int SB  = 1 + 15 + 3 * VEL_WIDTH;

    logic en;
    logic [LAT-1:0] r_vld;
    t_fold r_f_psi, r_f_gam;
    logic [SB-1:0] r_side0;
    logic [SB-1:0] r_side [NC+1];
    logic signed [VEL_WIDTH-1:0] r_vz_d [5];
    t_trig s, c, sg, cg;
    logic signed [VEL_WIDTH-1:0] m_x, m_y;
    logic signed [17:0] n_gsum;

    assign en      = !(r_vld[LAT-1] && i_stall);
    assign o_stall = !en;
    assign o_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    always_comb begin
        n_gsum = i_mode ? 18'(i_tilt_axis_angle)
                        : 18'(i_tilt_axis_angle) + 18'(i_fused_yaw);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f_psi <= fold_angle(18'(i_fused_yaw));
            r_f_gam <= fold_angle(n_gsum);
            r_side0 <= {i_mode, i_tilt_magnitude, i_vel_x, i_vel_y, i_vel_z};
        end
    end

    assign r_side[0] = r_side0;
    for (genvar g = 0; g < NC; g++) begin : g_side
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_side[g+1] <= r_side[g];
            end
        end
    end

    tpvfc_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_psi (
        .i_clk(i_clk), .i_en(en), .i_z(r_f_psi.z), .i_flip(r_f_psi.flip),
        .o_sin(s), .o_cos(c)
    );

    tpvfc_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_gam (
        .i_clk(i_clk), .i_en(en), .i_z(r_f_gam.z), .i_flip(r_f_gam.flip),
        .o_sin(sg), .o_cos(cg)
    );

    tpvfc_mac #(.VEL_WIDTH(VEL_WIDTH)) u_mac (
        .i_clk(i_clk), .i_en(en),
        .i_back(r_side[NC][SB-1]),
        .i_s(s), .i_c(c), .i_sg(sg), .i_cg(cg),
        .i_alpha(r_side[NC][SB-2 -: 15]),
        .i_vx(r_side[NC][3*VEL_WIDTH-1 -: VEL_WIDTH]),
        .i_vy(r_side[NC][2*VEL_WIDTH-1 -: VEL_WIDTH]),
        .i_vz(r_side[NC][VEL_WIDTH-1:0]),
        .o_x(m_x), .o_y(m_y)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_vz_d[0] <= r_side[NC][VEL_WIDTH-1:0];
            for (int k = 1; k < 5; k++) begin
                r_vz_d[k] <= r_vz_d[k-1];
            end
        end
    end

    assign o_out_x = m_x;
    assign o_out_y = m_y;
    assign o_out_z = r_vz_d[4];

    `TPV_ASSERT_NEXT(a_hold_valid, i_clk, i_rst_n, o_valid && i_stall, o_valid,
        "result dropped while stalled")
    `TPV_ASSERT_NEXT(a_hold_data, i_clk, i_rst_n, o_valid && i_stall,
        $stable(o_out_x) && $stable(o_out_y) && $stable(o_out_z),
        "stalled result changed")
    `TPV_ASSERT_IMPL(a_stall_only_full, i_clk, i_rst_n, o_stall, o_valid,
        "input stalled with no result held")

endmodule

FILE: hdl/tpvfc_cordic.sv
// ----------------------------------------------------------------------------
// Tilt phase velocity frame converter: pipelined CORDIC
// Rotation-mode CORDIC, one register stage per iteration, with stall.
// ----------------------------------------------------------------------------
module tpvfc_cordic
    import tpvfc_pkg::*;
#(
    parameter int STAGES = 16
) (
    input  logic  i_clk,
    input  logic  i_en,
    input  t_zang i_z,
    input  logic  i_flip,
    output t_trig o_sin,
    output t_trig o_cos
);

    localparam int N = (STAGES < ATAN_N) ? STAGES : ATAN_N;

    t_trig r_x [N+1];
    t_trig r_y [N+1];
    t_zang r_z [N+1];
    logic  r_f [N+1];

    always_comb begin
        r_x[0] = CORDIC_GAIN;
        r_y[0] = '0;
        r_z[0] = i_z;
        r_f[0] = i_flip;
    end

    for (genvar g = 0; g < N; g++) begin : g_stage
        t_trig n_x, n_y;
        t_zang n_z;
        always_comb begin
            if (!r_z[g][Z_W-1]) begin
                n_x = r_x[g] - (r_y[g] >>> g);
                n_y = r_y[g] + (r_x[g] >>> g);
                n_z = r_z[g] - t_zang'(atan_q30(g));
            end else begin
                n_x = r_x[g] + (r_y[g] >>> g);
                n_y = r_y[g] - (r_x[g] >>> g);
                n_z = r_z[g] + t_zang'(atan_q30(g));
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[g+1] <= n_x;
                r_y[g+1] <= n_y;
                r_z[g+1] <= n_z;
                r_f[g+1] <= r_f[g];
            end
        end
    end

    assign o_sin = r_f[N] ? -r_y[N] : r_y[N];
    assign o_cos = r_f[N] ? -r_x[N] : r_x[N];

endmodule

FILE: hdl/tpvfc_mac.sv
// ----------------------------------------------------------------------------
// Tilt phase velocity frame converter: product and sum stages
// Scales z coefficients, forms the six products, sums, rounds, saturates.
// ----------------------------------------------------------------------------
module tpvfc_mac
    import tpvfc_pkg::*;
#(
    parameter int VEL_WIDTH = 32
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic                        i_back,
    input  t_trig                       i_s,
    input  t_trig                       i_c,
    input  t_trig                       i_sg,
    input  t_trig                       i_cg,
    input  logic [14:0]                 i_alpha,
    input  logic signed [VEL_WIDTH-1:0] i_vx,
    input  logic signed [VEL_WIDTH-1:0] i_vy,
    input  logic signed [VEL_WIDTH-1:0] i_vz,
    output logic signed [VEL_WIDTH-1:0] o_x,
    output logic signed [VEL_WIDTH-1:0] o_y
);

    localparam int PW = TRIG_W + 2 + VEL_WIDTH;
    localparam int AW = PW + 2;
    localparam int KW = 48;

    // stage A: z coefficient products
    logic signed [KW-1:0] r_ks_p, r_kc_p;
    t_trig r_a_s, r_a_c;
    logic r_a_back;
    logic signed [VEL_WIDTH-1:0] r_a_vx, r_a_vy, r_a_vz;

    // stage B: signed coefficients
    logic signed [TRIG_W+1:0] r_b_c, r_b_s, r_b_ks, r_b_kc;
    logic signed [VEL_WIDTH-1:0] r_b_vx, r_b_vy, r_b_vz;

    // stage C: products
    logic signed [PW-1:0] r_p0, r_p1, r_p2, r_p3, r_p4, r_p5;

    // stage D: sums
    logic signed [AW-1:0] r_ax, r_ay;

    logic signed [KW-1:0] n_ks, n_kc;
    logic signed [TRIG_W+1:0] n_ks_q, n_kc_q, n_s_x;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ks_p   <= KW'(i_sg) * $signed({1'b0, i_alpha});
            r_kc_p   <= KW'(i_cg) * $signed({1'b0, i_alpha});
            r_a_s    <= i_s;
            r_a_c    <= i_c;
            r_a_back <= i_back;
            r_a_vx   <= i_vx;
            r_a_vy   <= i_vy;
            r_a_vz   <= i_vz;
        end
    end

    always_comb begin
        n_ks   = (r_ks_p + KW'(4096)) >>> 13;
        n_kc   = (r_kc_p + KW'(4096)) >>> 13;
        n_ks_q = n_ks[TRIG_W+1:0];
        n_kc_q = n_kc[TRIG_W+1:0];
        n_s_x  = (TRIG_W+2)'(r_a_s);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_c  <= (TRIG_W+2)'(r_a_c);
            r_b_s  <= r_a_back ? -n_s_x : n_s_x;
            r_b_ks <= r_a_back ? -n_ks_q : n_ks_q;
            r_b_kc <= r_a_back ? -n_kc_q : n_kc_q;
            r_b_vx <= r_a_vx;
            r_b_vy <= r_a_vy;
            r_b_vz <= r_a_vz;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p0 <= PW'(r_b_c) * PW'(r_b_vx);
            r_p1 <= PW'(-r_b_s) * PW'(r_b_vy);
            r_p2 <= PW'(-r_b_ks) * PW'(r_b_vz);
            r_p3 <= PW'(r_b_c) * PW'(r_b_vy);
            r_p4 <= PW'(r_b_s) * PW'(r_b_vx);
            r_p5 <= PW'(r_b_kc) * PW'(r_b_vz);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ax <= AW'(r_p0) + AW'(r_p1) + AW'(r_p2) + AW'(1 << 29);
            r_ay <= AW'(r_p3) + AW'(r_p4) + AW'(r_p5) + AW'(1 << 29);
        end
    end

    function automatic logic signed [VEL_WIDTH-1:0] sat(input logic signed [AW-1:0] a);
        logic signed [AW-31:0] q;
        q = a[AW-1:30];
        if (q > (AW-30)'((64'sd1 <<< (VEL_WIDTH-1)) - 1)) begin
            sat = {1'b0, {(VEL_WIDTH-1){1'b1}}};
        end else if (q < -(AW-30)'(64'sd1 <<< (VEL_WIDTH-1))) begin
            sat = {1'b1, {(VEL_WIDTH-1){1'b0}}};
        end else begin
            sat = q[VEL_WIDTH-1:0];
        end
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_x <= sat(r_ax);
            o_y <= sat(r_ay);
        end
    end

endmodule
